// ----- src/sid_pkg.sv -----
// sid_pkg: shared constants and types for the signed integer divider.
// No dependencies; imported by every module under src.
`default_nettype none

package sid_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Per-stage control that rides along with each word down the cell chain.
  typedef struct packed {
    logic valid;     // stage holds a live word
    logic negate;    // operand signs differ
    logic zero_div;  // divisor was zero
    logic sat;       // most negative / -1
  } sid_ctl_t;

endpackage : sid_pkg

`default_nettype wire

// ----- src/sid_prep.sv -----
// sid_prep: input stage, takes magnitudes and flags the special cases.
// Depends on sid_pkg.
`default_nettype none

module sid_prep import sid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  load,
  input  wire logic [DATA_WIDTH-1:0] num,
  input  wire logic [DATA_WIDTH-1:0] den,
  output sid_ctl_t                   ctl,
  output logic      [DATA_WIDTH-1:0] nmag,
  output logic      [DATA_WIDTH-1:0] dmag
);

  localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] AllOnes = {DATA_WIDTH{1'b1}};

  logic                  num_neg;
  logic                  den_neg;
  logic [DATA_WIDTH-1:0] nmag_next;
  logic [DATA_WIDTH-1:0] dmag_next;
  sid_ctl_t              ctl_next;

  assign num_neg = num[DATA_WIDTH-1];
  assign den_neg = den[DATA_WIDTH-1];

  // Most negative value maps to itself, which reads correctly as unsigned.
  assign nmag_next = num_neg ? (~num + 1'b1) : num;
  assign dmag_next = den_neg ? (~den + 1'b1) : den;

  always_comb begin
    ctl_next.valid    = load;
    ctl_next.negate   = num_neg ^ den_neg;
    ctl_next.zero_div = (den == '0);
    ctl_next.sat      = (num == MinVal) && (den == AllOnes);
  end

  // Only the valid bit is reset; the flags follow it without reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl.negate   <= ctl_next.negate;
      ctl.zero_div <= ctl_next.zero_div;
      ctl.sat      <= ctl_next.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag <= nmag_next;
      dmag <= dmag_next;
    end
  end

endmodule : sid_prep

`default_nettype wire

// ----- src/sid_cell.sv -----
// sid_cell: one restoring shift-subtract step, registered.
// Depends on sid_pkg.
`default_nettype none

module sid_cell import sid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire sid_ctl_t              ctl_in,
  input  wire logic [DATA_WIDTH-1:0] rem_in,
  input  wire logic [DATA_WIDTH-1:0] nq_in,   // dividend bits above, quotient bits below
  input  wire logic [DATA_WIDTH-1:0] den_in,
  output sid_ctl_t                   ctl_out,
  output logic      [DATA_WIDTH-1:0] rem_out,
  output logic      [DATA_WIDTH-1:0] nq_out,
  output logic      [DATA_WIDTH-1:0] den_out
);

  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  borrow;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // Live remainder is below the divisor, so it fits in DATA_WIDTH-1 bits.
  assign shifted  = {rem_in[DATA_WIDTH-2:0], nq_in[DATA_WIDTH-1]};
  assign diff     = {1'b0, shifted} - {1'b0, den_in};
  assign borrow   = diff[DATA_WIDTH];
  assign rem_next = borrow ? shifted : diff[DATA_WIDTH-1:0];
  assign nq_next  = {nq_in[DATA_WIDTH-2:0], ~borrow};

  // Only the valid bit is reset; the flags follow it without reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.negate   <= ctl_in.negate;
      ctl_out.zero_div <= ctl_in.zero_div;
      ctl_out.sat      <= ctl_in.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      nq_out  <= nq_next;
      den_out <= den_in;
    end
  end

endmodule : sid_cell

`default_nettype wire

// ----- src/signed_integer_divider.sv -----
// signed_integer_divider: top level, prep stage, cell chain and output register.
// Depends on sid_pkg, sid_prep, sid_cell.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_ready  | numerator, denominator (signed)
//   out      | out_valid/out_ready| quotient (signed), zero_divisor, saturated
//
// From accept to out_valid, the accepting edge loads the prep stage, then the word
// passes through one cell per quotient bit and then through the output register.
// The chain is a pipeline, so one word per cycle can go in while out_ready holds.
// A stalled output register freezes every stage at once; in_ready drops with it.
// Synchronous reset clears only the stage valid bits and out_valid.
`default_nettype none

module signed_integer_divider import sid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] numerator,
  input  wire logic [DATA_WIDTH-1:0] denominator,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DATA_WIDTH-1:0] quotient,
  output logic                       zero_divisor,
  output logic                       saturated
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // Whole chain moves when the output slot is empty or being drained.
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Stage k of the chain feeds cell k; stage DATA_WIDTH is the last cell output.
  sid_ctl_t              ctl_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_c [0:DATA_WIDTH];

  sid_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .load (in_valid),
    .num  (numerator),
    .den  (denominator),
    .ctl  (ctl_c[0]),
    .nmag (nq_c[0]),
    .dmag (den_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    sid_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .ctl_in  (ctl_c[k]),
      .rem_in  (rem_c[k]),
      .nq_in   (nq_c[k]),
      .den_in  (den_c[k]),
      .ctl_out (ctl_c[k+1]),
      .rem_out (rem_c[k+1]),
      .nq_out  (nq_c[k+1]),
      .den_out (den_c[k+1])
    );
  end

  // Sign fix-up and special cases ahead of the output register.
  // Final remainder and divisor are dropped here.
  sid_ctl_t              tail;
  logic [DATA_WIDTH-1:0] qmag;
  logic [DATA_WIDTH-1:0] quotient_next;

  assign tail = ctl_c[DATA_WIDTH];
  assign qmag = nq_c[DATA_WIDTH];

  always_comb begin
    priority if (tail.zero_div) begin
      quotient_next = '0;
    end else if (tail.sat) begin
      quotient_next = MaxPos;
    end else if (tail.negate) begin
      quotient_next = ~qmag + 1'b1;
    end else begin
      quotient_next = qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quotient     <= quotient_next;
      zero_divisor <= tail.zero_div;
      saturated    <= tail.sat && !tail.zero_div;
    end
  end

endmodule : signed_integer_divider

`default_nettype wire
